FILE: rtl/three_phase_scroll_wheel_decoder_assert.svh
// assertion macros for the scroll wheel decoder checker
`ifndef THREE_PHASE_SCROLL_WHEEL_DECODER_ASSERT_SVH
`define THREE_PHASE_SCROLL_WHEEL_DECODER_ASSERT_SVH

// same-cycle implication
`define SWD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scroll wheel assertion failed");

// next-cycle implication
`define SWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scroll wheel assertion failed");

`endif

FILE: rtl/swd_pkg.sv
package swd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SumW    = 12;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned ProdW   = SumW + RecipW;

  // floor(sum / 3) as (sum * 43691) >> 17, exact for any sum of three samples
  localparam logic [RecipW-1:0] MeanRecip = 16'd43691;
  localparam int unsigned       MeanShift = 17;

  localparam logic [SampleW-1:0] DeadbandReset = 10'd50;

  localparam logic signed [CountW-1:0] StepMax = 8'sd127;
  localparam logic signed [CountW-1:0] StepMin = -8'sd128;

  localparam logic [1:0] MotionNone  = 2'd0;
  localparam logic [1:0] MotionRight = 2'd1;
  localparam logic [1:0] MotionLeft  = 2'd2;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef struct packed {
    logic [SampleW-1:0] sample_one;
    logic [SampleW-1:0] sample_two;
    logic [SampleW-1:0] sample_three;
  } in_item_t;

  typedef struct packed {
    logic signed [CountW-1:0] step_count;
    logic [1:0]               motion;
  } out_item_t;

  typedef struct packed {
    logic near;
    dir_e dir;
  } lane_stat_t;

endpackage

FILE: rtl/swd_lane.sv
module swd_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [swd_pkg::SampleW-1:0]   sample_i,
  input  logic [swd_pkg::SampleW-1:0]   mean_i,
  input  logic [swd_pkg::SampleW-1:0]   deadband_i,
  input  logic                          rest_i,
  input  logic                          adv_i,
  output swd_pkg::lane_stat_t           stat_o
);
  import swd_pkg::*;

  logic [SampleW-1:0] ref_q, ref_d;
  logic [SampleW:0]   chg, chg_mag, dev, dev_mag, dev_twice;
  logic               big;

  // change against the reference
  assign chg     = {1'b0, sample_i} - {1'b0, ref_q};
  assign chg_mag = chg[SampleW] ? (~chg + 1'b1) : chg;
  assign big     = chg_mag > {1'b0, deadband_i};

  // deviation from the mean of the set
  assign dev       = {1'b0, sample_i} - {1'b0, mean_i};
  assign dev_mag   = dev[SampleW] ? (~dev + 1'b1) : dev;
  assign dev_twice = {dev_mag[SampleW-1:0], 1'b0};

  assign stat_o.near = dev_twice < {1'b0, deadband_i};
  assign stat_o.dir  = big ? (chg[SampleW] ? DIR_DOWN : DIR_UP) : DIR_NONE;

  always_comb begin
    ref_d = ref_q;
    if (adv_i && (rest_i || big)) begin
      ref_d = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else begin
      ref_q <= ref_d;
    end
  end

endmodule

FILE: rtl/swd_merge.sv
module swd_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swd_pkg::lane_stat_t [2:0] stat_i,
  input  logic                      adv_i,
  output logic                      rest_o,
  output swd_pkg::out_item_t        res_o
);
  import swd_pkg::*;

  logic signed [CountW-1:0] total_q, total_d;
  dir_e                     d1, d2, d3;
  logic                     right, left;

  // lane 2 carries the first electrode
  assign d1 = stat_i[2].dir;
  assign d2 = stat_i[1].dir;
  assign d3 = stat_i[0].dir;

  assign rest_o = stat_i[0].near && stat_i[1].near && stat_i[2].near;

  assign right = (d1 == DIR_NONE && d2 == DIR_UP   && d3 == DIR_DOWN) ||
                 (d1 == DIR_UP   && d2 == DIR_DOWN && d3 == DIR_NONE) ||
                 (d1 == DIR_DOWN && d2 == DIR_NONE && d3 == DIR_UP);
  assign left  = (d1 == DIR_UP   && d2 == DIR_NONE && d3 == DIR_DOWN) ||
                 (d1 == DIR_DOWN && d2 == DIR_UP   && d3 == DIR_NONE) ||
                 (d1 == DIR_NONE && d2 == DIR_DOWN && d3 == DIR_UP);

  always_comb begin
    total_d      = total_q;
    res_o.motion = MotionNone;
    if (rest_o) begin
      total_d = '0;
    end else if (right) begin
      res_o.motion = MotionRight;
      if (total_q != StepMax) begin
        total_d = total_q + 8'sd1;
      end
    end else if (left) begin
      res_o.motion = MotionLeft;
      if (total_q != StepMin) begin
        total_d = total_q - 8'sd1;
      end
    end
    res_o.step_count = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (adv_i) begin
      total_q <= total_d;
    end
  end

endmodule

FILE: rtl/three_phase_scroll_wheel_decoder.sv
// pipeline: a request is held in stage 1, then its result in the output register
// throughput: 1 request per cycle when not stalled; stage 1 computes the mean,
// stage 2 runs the lanes, writes the output and updates references and step total
// reset: references and step total clear to zero, deadband returns to 50,
// both pipeline stages empty; no clearing pass, requests are taken right away
module three_phase_scroll_wheel_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  swd_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output swd_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [swd_pkg::SampleW-1:0]   cfg_data_i
);
  import swd_pkg::*;

  // deadband register
  logic [SampleW-1:0] deadband_q;

  // stage 1: samples and their truncated mean
  logic                    s1_valid_q, s1_valid_d;
  logic [2:0][SampleW-1:0] smp_q;
  logic [SampleW-1:0]      mean_q;
  logic [SumW-1:0]         sum;
  logic [ProdW-1:0]        prod;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // handshake
  logic accept, out_ready, adv;

  // lanes and merge
  lane_stat_t [2:0] stat;
  logic             rest;
  out_item_t        res;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_ready;
  // only a held stage 1 blocks a new request
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // mean by reciprocal multiply, no divider
  assign sum  = SumW'(in_item_i.sample_one) + SumW'(in_item_i.sample_two)
              + SumW'(in_item_i.sample_three);
  assign prod = ProdW'(sum) * ProdW'(MeanRecip);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q  <= DeadbandReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        deadband_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[2] <= in_item_i.sample_one;
      smp_q[1] <= in_item_i.sample_two;
      smp_q[0] <= in_item_i.sample_three;
      mean_q   <= prod[MeanShift +: SampleW];
    end
    if (adv) begin
      out_item_q <= res;
    end
  end

  // one lane per electrode, each owns its reference
  for (genvar g = 0; g < 3; g++) begin : g_lane
    swd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sample_i   (smp_q[g]),
      .mean_i     (mean_q),
      .deadband_i (deadband_q),
      .rest_i     (rest),
      .adv_i      (adv),
      .stat_o     (stat[g])
    );
  end

  // rest detect, direction pattern match and saturating step total
  swd_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .adv_i  (adv),
    .rest_o (rest),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/swd_checker.sv
`include "three_phase_scroll_wheel_decoder_assert.svh"

module swd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input swd_pkg::out_item_t out_item_o
);
  import swd_pkg::*;

  // a held result stays put
  `SWD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // only a blocked output can push back on the input
  `SWD_ASSERT(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // motion code stays in its range
  `SWD_ASSERT(a_motion_code, out_valid_o, out_item_o.motion != 2'd3)

  // a right step never leaves the total at the lower limit
  `SWD_ASSERT(a_right_sat, out_valid_o && out_item_o.motion == MotionRight,
              out_item_o.step_count != StepMin)

endmodule

bind three_phase_scroll_wheel_decoder swd_checker u_swd_checker (.*);
